[rtl/tsr_pkg.sv]
// ----------------------------------------------------------------------------
// tsr_pkg
// Shared types, register codes and helpers for the tier switch register block.
// ----------------------------------------------------------------------------
package tsr_pkg;

    localparam int STACK_DEPTH_DEF = 8;
    localparam int TIER_W          = 7;

    // Access kind
    localparam logic FUNC_READ  = 1'b0;
    localparam logic FUNC_WRITE = 1'b1;

    // Register select codes
    localparam logic [2:0] REG_STATUS   = 3'd0;
    localparam logic [2:0] REG_ENTRY_LO = 3'd1;
    localparam logic [2:0] REG_ENTRY_HI = 3'd2;
    localparam logic [2:0] REG_REQUEST  = 3'd3;
    localparam logic [2:0] REG_CONTROL  = 3'd4;

    // Error flag bit positions (status byte 3)
    localparam int FLAG_INVALID   = 0;
    localparam int FLAG_OVERFLOW  = 1;
    localparam int FLAG_UNDERFLOW = 2;

    // Request byte fields
    localparam int REQ_POP_BIT = 7;

    // Control byte fields
    localparam int CTL_CLEAR_BIT = 0;

    typedef enum logic
    {
        ST_IDLE,
        ST_POP
    } state_t;

    typedef struct packed
    {
        logic wr_en;
        logic rd_en;
    } stack_ctl_t;

    function automatic logic [1:0] core_of(input logic [TIER_W-1:0] tier);
        logic [1:0] core;
        if (tier <= TIER_W'(2))
            core = 2'd0;
        else if (tier == TIER_W'(3))
            core = 2'd1;
        else if (tier <= TIER_W'(6))
            core = 2'd2;
        else
            core = 2'd3;
        return core;
    endfunction

endpackage

[rtl/tsr_if.sv]
// ----------------------------------------------------------------------------
// tsr_req_if / tsr_rsp_if
// Valid/ready channels for bus accesses and the bytes they return.
// ----------------------------------------------------------------------------
interface tsr_req_if;
    logic       valid;
    logic       ready;
    logic       func;
    logic [2:0] reg_sel;
    logic [1:0] byte_lane;
    logic [7:0] write_data;

    modport source
    (
        output valid,
        output func,
        output reg_sel,
        output byte_lane,
        output write_data,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  func,
        input  reg_sel,
        input  byte_lane,
        input  write_data,
        output ready
    );
endinterface

interface tsr_rsp_if;
    logic       valid;
    logic       ready;
    logic [7:0] read_data;

    modport source
    (
        output valid,
        output read_data,
        input  ready
    );

    modport sink
    (
        input  valid,
        input  read_data,
        output ready
    );
endinterface

[rtl/tier_switch_stack_registers.sv]
// ----------------------------------------------------------------------------
// tier_switch_stack_registers
// Byte-wide register block that switches execution tiers via a return stack.
// ----------------------------------------------------------------------------
// Each transfer on req is one byte access to status, entry low/high, request
// or control, and produces exactly one byte on rsp (zero for writes, control
// and unmapped selects). The response sits in an output register, so a new
// access is taken while the previous byte still waits on rsp, as long as that
// byte is taken in the same cycle. A successful pop (request write with bit 7
// set and a non-empty stack) passes through ST_POP: the previous tier lives in
// the return stack memory, whose read data is registered, and req.ready stays
// low in ST_POP while the active tier and core are reloaded from it. The
// return stack holds STACK_DEPTH tiers and has no reset; only entries written
// by earlier pushes are ever read.
// ----------------------------------------------------------------------------
module tier_switch_stack_registers
    import tsr_pkg::*;
#(
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
)
(
    input logic       clk,
    input logic       rst_n,
    tsr_req_if.sink   req,
    tsr_rsp_if.source rsp
);

    localparam int ADDR_W  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int DEPTH_W = $clog2(STACK_DEPTH + 1);

    // architectural state
    state_t             state_reg,    state_next;
    logic [7:0]         last_req_reg, last_req_next;
    logic [TIER_W-1:0]  tier_reg,     tier_next;
    logic [1:0]         core_reg,     core_next;
    logic [DEPTH_W-1:0] depth_reg,    depth_next;
    logic [2:0]         flags_reg,    flags_next;
    logic [31:0]        entry_lo_reg, entry_lo_next;
    logic [31:0]        entry_hi_reg, entry_hi_next;

    // response register
    logic               rsp_valid_reg, rsp_valid_next;
    logic [7:0]         rsp_data_reg,  rsp_data_next;

    // stack memory port
    stack_ctl_t         stk_ctl;
    logic [ADDR_W-1:0]  stk_waddr;
    logic [ADDR_W-1:0]  stk_raddr;
    logic [TIER_W-1:0]  stk_rdata;

    logic               accept;
    logic               rsp_take;
    logic               pop_start;
    logic [DEPTH_W-1:0] depth_dec;
    logic [TIER_W-1:0]  target;
    logic [31:0]        stat_bits;
    logic [4:0]         lane_base;

    tsr_stack
    #(
        .DEPTH  (STACK_DEPTH),
        .ADDR_W (ADDR_W)
    )
    u_stack
    (
        .clk   (clk),
        .ctl   (stk_ctl),
        .waddr (stk_waddr),
        .wdata (tier_reg),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign rsp_take  = rsp_valid_reg && rsp.ready;
    // new access only when idle and the response slot is free or draining
    assign req.ready = (state_reg == ST_IDLE) && (!rsp_valid_reg || rsp.ready);
    assign accept    = req.valid && req.ready;

    assign rsp.valid     = rsp_valid_reg;
    assign rsp.read_data = rsp_data_reg;

    assign depth_dec = depth_reg - DEPTH_W'(1);
    assign target    = req.write_data[TIER_W-1:0];
    assign lane_base = {req.byte_lane, 3'b000};
    assign stk_waddr = depth_reg[ADDR_W-1:0];
    assign stk_raddr = depth_dec[ADDR_W-1:0];

    assign stat_bits = {5'b0, flags_reg, 6'b0, core_reg, 8'(depth_reg), 1'b0, tier_reg};

    always_comb
    begin
        state_next     = state_reg;
        last_req_next  = last_req_reg;
        tier_next      = tier_reg;
        core_next      = core_reg;
        depth_next     = depth_reg;
        flags_next     = flags_reg;
        entry_lo_next  = entry_lo_reg;
        entry_hi_next  = entry_hi_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_data_next  = rsp_data_reg;
        stk_ctl        = '0;
        pop_start      = 1'b0;

        if (rsp_take)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_data_next  = 8'h00;

                    if (req.func == FUNC_WRITE)
                    begin
                        unique case (req.reg_sel)
                            REG_ENTRY_LO: entry_lo_next[lane_base +: 8] = req.write_data;
                            REG_ENTRY_HI: entry_hi_next[lane_base +: 8] = req.write_data;
                            REG_REQUEST:
                            begin
                                last_req_next = req.write_data;
                                if (req.write_data[REQ_POP_BIT])
                                begin
                                    if (depth_reg == '0)
                                    begin
                                        flags_next[FLAG_UNDERFLOW] = 1'b1;
                                    end
                                    else
                                    begin
                                        // tier comes back from memory next cycle
                                        depth_next    = depth_dec;
                                        stk_ctl.rd_en = 1'b1;
                                        pop_start     = 1'b1;
                                        state_next    = ST_POP;
                                    end
                                end
                                else if (target <= tier_reg)
                                begin
                                    flags_next[FLAG_INVALID] = 1'b1;
                                end
                                else if (depth_reg == DEPTH_W'(STACK_DEPTH))
                                begin
                                    flags_next[FLAG_OVERFLOW] = 1'b1;
                                end
                                else
                                begin
                                    stk_ctl.wr_en = 1'b1;
                                    depth_next    = depth_reg + DEPTH_W'(1);
                                    tier_next     = target;
                                    core_next     = core_of(target);
                                end
                            end
                            REG_CONTROL:
                            begin
                                if (req.write_data[CTL_CLEAR_BIT])
                                begin
                                    flags_next = '0;
                                end
                            end
                            default: ;
                        endcase
                    end
                    else
                    begin
                        unique case (req.reg_sel)
                            REG_STATUS:   rsp_data_next = stat_bits[lane_base +: 8];
                            REG_ENTRY_LO: rsp_data_next = entry_lo_reg[lane_base +: 8];
                            REG_ENTRY_HI: rsp_data_next = entry_hi_reg[lane_base +: 8];
                            REG_REQUEST:  rsp_data_next = last_req_reg;
                            default:      rsp_data_next = 8'h00;
                        endcase
                    end
                end
            end

            ST_POP:
            begin
                tier_next  = stk_rdata;
                core_next  = core_of(stk_rdata);
                state_next = ST_IDLE;
            end

            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            last_req_reg  <= '0;
            tier_reg      <= '0;
            core_reg      <= '0;
            depth_reg     <= '0;
            flags_reg     <= '0;
            entry_lo_reg  <= '0;
            entry_hi_reg  <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            last_req_reg  <= last_req_next;
            tier_reg      <= tier_next;
            core_reg      <= core_next;
            depth_reg     <= depth_next;
            flags_reg     <= flags_next;
            entry_lo_reg  <= entry_lo_next;
            entry_hi_reg  <= entry_hi_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_data_reg <= rsp_data_next;
    end

`ifndef ASSERT_OFF
    a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
        depth_reg <= DEPTH_W'(STACK_DEPTH))
        else $error("return depth beyond stack size");

    a_pop_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_POP |-> !req.ready)
        else $error("access taken while pop reload pending");

    a_pop_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
        pop_start |=> state_reg == ST_POP ##1 state_reg == ST_IDLE)
        else $error("pop reload did not finish in one cycle");

    a_core_tracks_tier: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == ST_IDLE |-> core_reg == core_of(tier_reg))
        else $error("active core out of step with active tier");

    a_rsp_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> rsp_valid_reg)
        else $error("accepted access produced no response");
`endif

endmodule

[rtl/tsr_stack.sv]
// ----------------------------------------------------------------------------
// tsr_stack
// Return stack storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module tsr_stack
    import tsr_pkg::*;
#(
    parameter int DEPTH  = STACK_DEPTH_DEF,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
)
(
    input  logic              clk,
    input  stack_ctl_t        ctl,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [TIER_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [TIER_W-1:0] rdata
);

    logic [TIER_W-1:0] mem [DEPTH];
    logic [TIER_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (ctl.wr_en)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.rd_en)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule
